// ----- rtl/tcdm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcdm_pkg
// Types, constants and helper functions shared by the two-color dither mix
// search pipeline.
// ----------------------------------------------------------------------------
package tcdm_pkg;

    localparam int NPAIR = 16;
    localparam int NRATIO = 17;
    localparam int NCAND = NPAIR * NRATIO;

    typedef enum logic [2:0] {
        REG_BACKDROP = 3'd0,
        REG_SUBPAL0  = 3'd1,
        REG_SUBPAL1  = 3'd2,
        REG_SUBPAL2  = 3'd3,
        REG_SUBPAL3  = 3'd4
    } t_reg_idx;

    localparam logic [5:0]  BACKDROP_RST = 6'd15;
    localparam logic [17:0] SUBPAL0_RST  = 18'd197632;
    localparam logic [17:0] SUBPAL1_RST  = 18'd161223;
    localparam logic [17:0] SUBPAL2_RST  = 18'd157062;
    localparam logic [17:0] SUBPAL3_RST  = 18'd169545;

    typedef struct packed {
        logic [1:0] subpalette;
        logic [7:0] target_red;
        logic [7:0] target_green;
        logic [7:0] target_blue;
    } t_in;

    typedef struct packed {
        logic [1:0]  first_slot;
        logic [1:0]  second_slot;
        logic [4:0]  mix_ratio;
        logic [7:0]  error_value;
        logic [31:0] dither_codes;
    } t_out;

    typedef struct packed {
        logic [25:0] d;
        logic [1:0]  a;
        logic [1:0]  b;
        logic [4:0]  r;
    } t_cand;

    typedef struct packed {
        t_cand      c;
        logic [8:0] m;
    } t_qst;

    // Console palette, red in the top byte.
    localparam logic [23:0] COLOR_ROM [64] = '{
        24'h808080, 24'h003DA6, 24'h0012B0, 24'h440096,
        24'hA1005E, 24'hC70028, 24'hBA0600, 24'h8C1700,
        24'h5C2F00, 24'h104500, 24'h054A00, 24'h00472E,
        24'h004166, 24'h000000, 24'h050505, 24'h050505,
        24'hC7C7C7, 24'h0077FF, 24'h2155FF, 24'h8237FA,
        24'hEB2FB5, 24'hFF2950, 24'hFF2200, 24'hD63200,
        24'hC46200, 24'h358000, 24'h058F00, 24'h008A55,
        24'h0099CC, 24'h212121, 24'h090909, 24'h090909,
        24'hFFFFFF, 24'h0FD7FF, 24'h69A2FF, 24'hD480FF,
        24'hFF45F3, 24'hFF618B, 24'hFF8833, 24'hFF9C12,
        24'hFABC20, 24'h9FE30E, 24'h2BF035, 24'h0CF0A4,
        24'h05FBFF, 24'h5E5E5E, 24'h0D0D0D, 24'h0D0D0D,
        24'hFFFFFF, 24'hA6FCFF, 24'hB3ECFF, 24'hDAABEB,
        24'hFFA8F9, 24'hFFABB3, 24'hFFD2B0, 24'hFFEFA6,
        24'hFFF79C, 24'hD7E895, 24'hA6EDAF, 24'hA2F2DA,
        24'h99FFFC, 24'hDDDDDD, 24'h111111, 24'h111111
    };

    localparam logic [3:0] BAYER [16] = '{
        4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
        4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5
    };

    function automatic logic [25:0] sq26(input logic signed [13:0] x);
        logic signed [27:0] p;
        p = x * x;
        return p[25:0];
    endfunction

    // Keeps the earlier candidate on a tie.
    function automatic t_cand pick_min(input t_cand x, input t_cand y);
        return (y.d < x.d) ? y : x;
    endfunction

    // Rounding threshold 192*(2c-1)^2: sqrt(D/768) reaches c-0.5 here.
    function automatic logic [27:0] rnd_thr(input logic [8:0] c);
        logic [9:0]  o;
        logic [19:0] s;
        o = {c, 1'b0} - 10'd1;
        s = o * o;
        return 28'({s, 7'b0}) + 28'({s, 6'b0});
    endfunction

endpackage
`default_nettype wire

// ----- rtl/two_color_dither_mix_search_top.sv -----
`default_nettype none
// A beat passes the lookup, mix-error, square-sum, tree and root registers into r_out.
// Throughput: one beat per cycle while not stalled; all 272 mixes are scored in
// parallel lanes, reduced by a registered compare tree, and the error root is found
// one bit per stage. Stalls freeze the whole pipeline while the output beat waits.
// Reset (synchronous, active low) clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// two_color_dither_mix_search_top
// Best two-color ordered dither mix of a target color within one subpalette.
// ----------------------------------------------------------------------------
module two_color_dither_mix_search_top
    import tcdm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [17:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out
);

    localparam int NSTG = 18;

    logic [5:0]  r_backdrop;
    logic [17:0] r_subpal [4];
    logic [NSTG-1:0] r_vld;
    logic w_en;

    logic [7:0] r_s1_rgb [4][3];
    logic [7:0] r_s1_tgt [3];
    logic signed [13:0] r_s2_diff [NCAND][3];
    t_cand r_s3 [NCAND];
    t_cand r_t1 [68];
    t_cand r_t2 [17];
    t_cand r_t3 [5];
    t_cand r_t4 [2];
    t_qst  r_q [10];
    t_out  r_out;

    t_cand n_t1 [68];
    t_cand n_t2 [17];
    t_cand n_t3 [5];
    t_cand n_t4 [2];
    t_cand n_t5;
    t_qst  n_q [10];
    t_out  n_out;
    logic [5:0] w_slot_idx [4];

    assign w_en = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready = w_en;
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backdrop <= BACKDROP_RST;
            r_subpal[0] <= SUBPAL0_RST;
            r_subpal[1] <= SUBPAL1_RST;
            r_subpal[2] <= SUBPAL2_RST;
            r_subpal[3] <= SUBPAL3_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_BACKDROP: r_backdrop <= i_cfg_data[5:0];
                REG_SUBPAL0:  r_subpal[0] <= i_cfg_data;
                REG_SUBPAL1:  r_subpal[1] <= i_cfg_data;
                REG_SUBPAL2:  r_subpal[2] <= i_cfg_data;
                REG_SUBPAL3:  r_subpal[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    always_comb begin
        w_slot_idx[0] = r_backdrop;
        for (int s = 1; s < 4; s++) begin
            w_slot_idx[s] = r_subpal[i_in.subpalette][6*s-1 -: 6];
        end
    end

    // Stage 1: lookup. Stage 2: per-channel mix errors. Then sums, tree, root, out.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 4; s++) begin
                r_s1_rgb[s][0] <= COLOR_ROM[w_slot_idx[s]][23:16];
                r_s1_rgb[s][1] <= COLOR_ROM[w_slot_idx[s]][15:8];
                r_s1_rgb[s][2] <= COLOR_ROM[w_slot_idx[s]][7:0];
            end
            r_s1_tgt[0] <= i_in.target_red;
            r_s1_tgt[1] <= i_in.target_green;
            r_s1_tgt[2] <= i_in.target_blue;
            for (int p = 0; p < NPAIR; p++) begin
                for (int r = 0; r < NRATIO; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_s2_diff[p*NRATIO+r][c] <=
                            $signed({1'b0, 13'(13'(r_s1_rgb[p/4][c]) * 13'(16 - r)
                                         + 13'(r_s1_rgb[p%4][c]) * 13'(r))})
                            - $signed({2'b0, r_s1_tgt[c], 4'b0});
                    end
                end
            end
            for (int p = 0; p < NPAIR; p++) begin
                for (int r = 0; r < NRATIO; r++) begin
                    r_s3[p*NRATIO+r].d <= sq26(r_s2_diff[p*NRATIO+r][0])
                                        + sq26(r_s2_diff[p*NRATIO+r][1])
                                        + sq26(r_s2_diff[p*NRATIO+r][2]);
                    r_s3[p*NRATIO+r].a <= 2'(p / 4);
                    r_s3[p*NRATIO+r].b <= 2'(p % 4);
                    r_s3[p*NRATIO+r].r <= 5'(r);
                end
            end
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
            r_t4 <= n_t4;
            for (int k = 0; k < 10; k++) begin
                r_q[k] <= n_q[k];
            end
            r_out <= n_out;
        end
    end

    // Minimum tree; the lower-indexed (earlier) candidate always sits on the left.
    always_comb begin
        t_cand l1 [136];
        t_cand l2 [34];
        t_cand l3 [9];
        t_cand l4 [3];
        for (int i = 0; i < 136; i++) l1[i] = pick_min(r_s3[2*i], r_s3[2*i+1]);
        for (int i = 0; i < 68; i++) n_t1[i] = pick_min(l1[2*i], l1[2*i+1]);
        for (int i = 0; i < 34; i++) l2[i] = pick_min(r_t1[2*i], r_t1[2*i+1]);
        for (int i = 0; i < 17; i++) n_t2[i] = pick_min(l2[2*i], l2[2*i+1]);
        for (int i = 0; i < 8; i++) l3[i] = pick_min(r_t2[2*i], r_t2[2*i+1]);
        l3[8] = r_t2[16];
        for (int i = 0; i < 4; i++) n_t3[i] = pick_min(l3[2*i], l3[2*i+1]);
        n_t3[4] = l3[8];
        l4[0] = pick_min(r_t3[0], r_t3[1]);
        l4[1] = pick_min(r_t3[2], r_t3[3]);
        l4[2] = r_t3[4];
        n_t4[0] = pick_min(l4[0], l4[1]);
        n_t4[1] = l4[2];
        n_t5 = pick_min(r_t4[0], r_t4[1]);
    end

    // Rounded root: greedy search for the largest m whose threshold is not above D.
    always_comb begin
        logic [8:0] cnd;
        n_q[0].c = n_t5;
        n_q[0].m = '0;
        for (int k = 0; k < 9; k++) begin
            cnd = r_q[k].m | (9'd1 << (8 - k));
            n_q[k+1] = r_q[k];
            if (rnd_thr(cnd) <= 28'(r_q[k].c.d)) begin
                n_q[k+1].m = cnd;
            end
        end
    end

    always_comb begin
        logic [8:0] m;
        m = r_q[9].m;
        // Exactly halfway between two integers: round to the even one.
        if (m != 9'd0 && m[0] && rnd_thr(m) == 28'(r_q[9].c.d)) begin
            m = m - 9'd1;
        end
        n_out.first_slot  = r_q[9].c.a;
        n_out.second_slot = r_q[9].c.b;
        n_out.mix_ratio   = r_q[9].c.r;
        n_out.error_value = m[8] ? 8'd255 : m[7:0];
        for (int k = 0; k < 16; k++) begin
            n_out.dither_codes[2*k +: 2] =
                (5'(BAYER[k]) < r_q[9].c.r) ? r_q[9].c.b : r_q[9].c.a;
        end
    end

`ifndef SYNTHESIS
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.mix_ratio <= 5'd16)
        else $error("mix ratio above sixteen");
    a_codes_pure_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.mix_ratio == 5'd0)
        |-> o_out.dither_codes == {16{o_out.first_slot}})
        else $error("ratio zero must give only the first slot");
    a_codes_pure_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.mix_ratio == 5'd16)
        |-> o_out.dither_codes == {16{o_out.second_slot}})
        else $error("ratio sixteen must give only the second slot");
`endif

endmodule
`default_nettype wire
